>>> rtl/core/spi_eas_pkg.sv
// shared types and constants of the spi eeprom access sequencer
package spi_eas_pkg;

  // input item kinds
  localparam logic [2:0] KIND_START_RD = 3'd0;
  localparam logic [2:0] KIND_START_WR = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD  = 3'd2;
  localparam logic [2:0] KIND_REPLY    = 3'd3;
  localparam logic [2:0] KIND_TICK     = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE_LOG2 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS     = 4'd1;

  localparam logic [3:0]  PAGE_SIZE_LOG2_RST = 4'd8;
  localparam logic [15:0] TIMEOUT_MS_RST     = 16'd100;

  // spi command bytes
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_WRITE = 8'h02;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] DUMMY     = 8'h00;

  localparam logic [7:0] STATUS_OK      = 8'd0;
  localparam logic [7:0] STATUS_TIMEOUT = 8'd1;

  localparam logic [15:0] TICKS_MAX = 16'hffff;

  localparam int unsigned MAX_RESULTS = 4;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_POLL_CMD,
    PH_POLL_STAT,
    PH_WREN,
    PH_HDR_CMD,
    PH_HDR_ADDR,
    PH_RD_DATA,
    PH_WR_PAYLOAD,
    PH_WR_DATA
  } phase_t;

  typedef enum logic [2:0] {
    ACT_SEL_LOW  = 3'd0,
    ACT_SEL_HIGH = 3'd1,
    ACT_XCHG     = 3'd2,
    ACT_READ     = 3'd3,
    ACT_DONE     = 3'd4
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] value;
  } result_t;

  // all results caused by one input item, entry 0 first
  typedef struct packed {
    logic [2:0]                   count;
    result_t [MAX_RESULTS-1:0]    res;
  } bundle_t;

endpackage

>>> rtl/core/spi_eas_if.sv
// channel interfaces: request items, result items, configuration writes
interface spi_eas_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [23:0] address;
  logic [15:0] length;
  logic [7:0]  data_byte;

  modport source (output valid, kind, address, length, data_byte, input ready);
  modport sink   (input valid, kind, address, length, data_byte, output ready);
endinterface

interface spi_eas_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] value;
  logic       last;

  modport source (output valid, action, value, last, input ready);
  modport sink   (input valid, action, value, last, output ready);
endinterface

interface spi_eas_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [spi_eas_pkg::CFG_IDX_W-1:0]  index;
  logic [spi_eas_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/spi_eas_core.sv
// sequencer state and combinational step logic
module spi_eas_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [2:0]           kind,
  input  logic [23:0]          address,
  input  logic [15:0]          length,
  input  logic [7:0]           data_byte,
  input  logic [3:0]           page_size_log2,
  input  logic [15:0]          timeout_ms,
  output logic                 push,
  output spi_eas_pkg::bundle_t bundle
);

  spi_eas_pkg::phase_t phase, phase_next;
  logic        is_write, is_write_next;
  logic [23:0] current_address, current_address_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] wait_ticks, wait_ticks_next;
  logic [1:0]  header_index, header_index_next;

  logic [23:0] addr_inc;
  logic [15:0] left_dec;
  logic [15:0] page_mask;
  logic [7:0]  addr_byte;

  function automatic spi_eas_pkg::result_t mk(spi_eas_pkg::action_t a, logic [7:0] v);
    spi_eas_pkg::result_t r;
    r.action = a;
    r.value  = v;
    return r;
  endfunction

  assign addr_inc  = current_address + 24'd1;
  assign left_dec  = bytes_left - 16'd1;
  assign page_mask = (16'd1 << page_size_log2) - 16'd1;

  // address byte for the next header slot, high byte first
  always_comb begin
    unique case (header_index_next)
      2'd0:    addr_byte = current_address[23:16];
      2'd1:    addr_byte = current_address[15:8];
      default: addr_byte = current_address[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_next           = phase;
    is_write_next        = is_write;
    current_address_next = current_address;
    bytes_left_next      = bytes_left;
    wait_ticks_next      = wait_ticks;
    header_index_next    = header_index;
    if (fire) begin
      unique case (kind)
        spi_eas_pkg::KIND_START_RD, spi_eas_pkg::KIND_START_WR: begin
          if (phase == spi_eas_pkg::PH_IDLE) begin
            is_write_next        = kind[0];
            current_address_next = address;
            bytes_left_next      = length;
            header_index_next    = 2'd0;
            wait_ticks_next      = 16'd0;
            phase_next           = spi_eas_pkg::PH_POLL_CMD;
          end
        end
        spi_eas_pkg::KIND_TICK: begin
          if ((phase == spi_eas_pkg::PH_POLL_CMD || phase == spi_eas_pkg::PH_POLL_STAT)
              && wait_ticks != spi_eas_pkg::TICKS_MAX) begin
            wait_ticks_next = wait_ticks + 16'd1;
          end
        end
        spi_eas_pkg::KIND_PAYLOAD: begin
          if (phase == spi_eas_pkg::PH_WR_PAYLOAD) phase_next = spi_eas_pkg::PH_WR_DATA;
        end
        spi_eas_pkg::KIND_REPLY: begin
          unique case (phase)
            spi_eas_pkg::PH_POLL_CMD: phase_next = spi_eas_pkg::PH_POLL_STAT;
            spi_eas_pkg::PH_POLL_STAT: begin
              if (data_byte[0]) begin
                if (wait_ticks >= timeout_ms) phase_next = spi_eas_pkg::PH_IDLE;
                else phase_next = spi_eas_pkg::PH_POLL_CMD;
              end else if (is_write) begin
                phase_next = spi_eas_pkg::PH_WREN;
              end else begin
                phase_next = spi_eas_pkg::PH_HDR_CMD;
              end
            end
            spi_eas_pkg::PH_WREN: phase_next = spi_eas_pkg::PH_HDR_CMD;
            spi_eas_pkg::PH_HDR_CMD: begin
              header_index_next = 2'd0;
              phase_next        = spi_eas_pkg::PH_HDR_ADDR;
            end
            spi_eas_pkg::PH_HDR_ADDR: begin
              if (header_index >= 2'd2) begin
                header_index_next = 2'd0;
                if (bytes_left == 16'd0) phase_next = spi_eas_pkg::PH_IDLE;
                else if (is_write) phase_next = spi_eas_pkg::PH_WR_PAYLOAD;
                else phase_next = spi_eas_pkg::PH_RD_DATA;
              end else begin
                header_index_next = header_index + 2'd1;
              end
            end
            spi_eas_pkg::PH_RD_DATA: begin
              bytes_left_next      = left_dec;
              current_address_next = addr_inc;
              if (left_dec == 16'd0) phase_next = spi_eas_pkg::PH_IDLE;
            end
            spi_eas_pkg::PH_WR_DATA: begin
              bytes_left_next      = left_dec;
              current_address_next = addr_inc;
              if (left_dec == 16'd0) begin
                phase_next = spi_eas_pkg::PH_IDLE;
              end else if ((addr_inc[15:0] & page_mask) == 16'd0) begin
                wait_ticks_next = 16'd0;
                phase_next      = spi_eas_pkg::PH_POLL_CMD;
              end else begin
                phase_next = spi_eas_pkg::PH_WR_PAYLOAD;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // results of the item
  always_comb begin
    bundle = '0;
    if (fire) begin
      unique case (kind)
        spi_eas_pkg::KIND_START_RD, spi_eas_pkg::KIND_START_WR: begin
          if (phase == spi_eas_pkg::PH_IDLE) begin
            bundle.count  = 3'd2;
            bundle.res[0] = mk(spi_eas_pkg::ACT_SEL_LOW, 8'd0);
            bundle.res[1] = mk(spi_eas_pkg::ACT_XCHG, spi_eas_pkg::CMD_RDSR);
          end
        end
        spi_eas_pkg::KIND_PAYLOAD: begin
          if (phase == spi_eas_pkg::PH_WR_PAYLOAD) begin
            bundle.count  = 3'd1;
            bundle.res[0] = mk(spi_eas_pkg::ACT_XCHG, data_byte);
          end
        end
        spi_eas_pkg::KIND_REPLY: begin
          unique case (phase)
            spi_eas_pkg::PH_POLL_CMD: begin
              bundle.count  = 3'd1;
              bundle.res[0] = mk(spi_eas_pkg::ACT_XCHG, spi_eas_pkg::DUMMY);
            end
            spi_eas_pkg::PH_POLL_STAT: begin
              bundle.res[0] = mk(spi_eas_pkg::ACT_SEL_HIGH, 8'd0);
              if (data_byte[0] && wait_ticks >= timeout_ms) begin
                bundle.count  = 3'd2;
                bundle.res[1] = mk(spi_eas_pkg::ACT_DONE, spi_eas_pkg::STATUS_TIMEOUT);
              end else begin
                bundle.count  = 3'd3;
                bundle.res[1] = mk(spi_eas_pkg::ACT_SEL_LOW, 8'd0);
                if (data_byte[0])
                  bundle.res[2] = mk(spi_eas_pkg::ACT_XCHG, spi_eas_pkg::CMD_RDSR);
                else if (is_write)
                  bundle.res[2] = mk(spi_eas_pkg::ACT_XCHG, spi_eas_pkg::CMD_WREN);
                else
                  bundle.res[2] = mk(spi_eas_pkg::ACT_XCHG, spi_eas_pkg::CMD_READ);
              end
            end
            spi_eas_pkg::PH_WREN: begin
              bundle.count  = 3'd3;
              bundle.res[0] = mk(spi_eas_pkg::ACT_SEL_HIGH, 8'd0);
              bundle.res[1] = mk(spi_eas_pkg::ACT_SEL_LOW, 8'd0);
              bundle.res[2] = mk(spi_eas_pkg::ACT_XCHG, spi_eas_pkg::CMD_WRITE);
            end
            spi_eas_pkg::PH_HDR_CMD, spi_eas_pkg::PH_HDR_ADDR: begin
              if (phase == spi_eas_pkg::PH_HDR_ADDR && header_index >= 2'd2) begin
                if (bytes_left == 16'd0) begin
                  bundle.count  = 3'd2;
                  bundle.res[0] = mk(spi_eas_pkg::ACT_SEL_HIGH, 8'd0);
                  bundle.res[1] = mk(spi_eas_pkg::ACT_DONE, spi_eas_pkg::STATUS_OK);
                end else if (!is_write) begin
                  bundle.count  = 3'd1;
                  bundle.res[0] = mk(spi_eas_pkg::ACT_XCHG, spi_eas_pkg::DUMMY);
                end
              end else begin
                bundle.count  = 3'd1;
                bundle.res[0] = mk(spi_eas_pkg::ACT_XCHG, addr_byte);
              end
            end
            spi_eas_pkg::PH_RD_DATA: begin
              bundle.res[0] = mk(spi_eas_pkg::ACT_READ, data_byte);
              if (left_dec == 16'd0) begin
                bundle.count  = 3'd3;
                bundle.res[1] = mk(spi_eas_pkg::ACT_SEL_HIGH, 8'd0);
                bundle.res[2] = mk(spi_eas_pkg::ACT_DONE, spi_eas_pkg::STATUS_OK);
              end else begin
                bundle.count  = 3'd2;
                bundle.res[1] = mk(spi_eas_pkg::ACT_XCHG, spi_eas_pkg::DUMMY);
              end
            end
            spi_eas_pkg::PH_WR_DATA: begin
              if (left_dec == 16'd0) begin
                bundle.count  = 3'd2;
                bundle.res[0] = mk(spi_eas_pkg::ACT_SEL_HIGH, 8'd0);
                bundle.res[1] = mk(spi_eas_pkg::ACT_DONE, spi_eas_pkg::STATUS_OK);
              end else if ((addr_inc[15:0] & page_mask) == 16'd0) begin
                // page boundary: close the frame and poll again
                bundle.count  = 3'd3;
                bundle.res[0] = mk(spi_eas_pkg::ACT_SEL_HIGH, 8'd0);
                bundle.res[1] = mk(spi_eas_pkg::ACT_SEL_LOW, 8'd0);
                bundle.res[2] = mk(spi_eas_pkg::ACT_XCHG, spi_eas_pkg::CMD_RDSR);
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign push = (bundle.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= spi_eas_pkg::PH_IDLE;
      is_write        <= 1'b0;
      current_address <= 24'd0;
      bytes_left      <= 16'd0;
      wait_ticks      <= 16'd0;
      header_index    <= 2'd0;
    end else begin
      phase           <= phase_next;
      is_write        <= is_write_next;
      current_address <= current_address_next;
      bytes_left      <= bytes_left_next;
      wait_ticks      <= wait_ticks_next;
      header_index    <= header_index_next;
    end
  end

  a_hidx_range: assert property (@(posedge clk) disable iff (rst)
    header_index != 2'd3)
    else $error("header index out of range");

  a_start_two: assert property (@(posedge clk) disable iff (rst)
    (fire && phase == spi_eas_pkg::PH_IDLE
     && (kind == spi_eas_pkg::KIND_START_RD || kind == spi_eas_pkg::KIND_START_WR))
    |=> phase == spi_eas_pkg::PH_POLL_CMD && wait_ticks == 16'd0)
    else $error("start did not enter status poll");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (fire && phase == spi_eas_pkg::PH_IDLE && kind != spi_eas_pkg::KIND_START_RD
     && kind != spi_eas_pkg::KIND_START_WR) |-> !push)
    else $error("results produced while idle");

endmodule

>>> rtl/core/spi_eas_outq.sv
// two-deep bundle queue with a serializer onto the result channel
module spi_eas_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  spi_eas_pkg::bundle_t bundle,
  output logic                 space,
  output logic                 valid,
  input  logic                 ready,
  output logic [2:0]           action,
  output logic [7:0]           value,
  output logic                 last
);

  spi_eas_pkg::bundle_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] cnt, cnt_next;
  logic [1:0] idx;
  logic       pop;
  spi_eas_pkg::bundle_t  head;
  spi_eas_pkg::result_t  cur;

  assign head   = slots[rd_ptr];
  assign cur    = head.res[idx];
  assign space  = (cnt != 2'd2);
  assign valid  = (cnt != 2'd0);
  assign action = cur.action;
  assign value  = cur.value;
  assign last   = (idx == 2'(head.count - 3'd1));
  assign pop    = valid && ready && last;

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_next = cnt + 2'd1;
      2'b01:   cnt_next = cnt - 2'd1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
      idx    <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        idx    <= 2'd0;
      end else if (valid && ready) begin
        idx <= idx + 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> space)
    else $error("bundle pushed into a full queue");

  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    valid |-> head.count != 3'd0 && {1'b0, idx} < head.count)
    else $error("serializer index beyond bundle");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3 && ((cnt == 2'd0 || cnt == 2'd2) == (wr_ptr == rd_ptr)))
    else $error("queue pointers and fill count disagree");

endmodule

>>> rtl/core/spi_eeprom_access_sequencer_unit.sv
// top level of the spi eeprom access sequencer
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    kind, address, length, data_byte
//  rsp      out  valid/ready    action, value, last
//  cfg      in   valid/ready    index, data (0 page_size_log2, 1 timeout_ms)
//
// each request item is stepped in the cycle it is accepted; any results (up to
// three) form one bundle in a two-deep queue and go out one per rsp.ready cycle
// req.ready is low only while both queue slots hold undelivered bundles, so
// items are taken every cycle as long as rsp keeps up with their results
// cfg.ready is always high; rst (synchronous) idles the sequencer, empties
// the queue and restores page_size_log2 = 8, timeout_ms = 100
module spi_eeprom_access_sequencer_unit (
  input  logic          clk,
  input  logic          rst,
  spi_eas_req_if.sink   req,
  spi_eas_rsp_if.source rsp,
  spi_eas_cfg_if.sink   cfg
);

  // configuration registers
  logic [3:0]  page_size_log2;
  logic [15:0] timeout_ms;

  logic                 fire;
  logic                 push;
  logic                 space;
  spi_eas_pkg::bundle_t bundle;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size_log2 <= spi_eas_pkg::PAGE_SIZE_LOG2_RST;
      timeout_ms     <= spi_eas_pkg::TIMEOUT_MS_RST;
    end else if (cfg.valid) begin
      // writes to indexes past the register list are dropped
      if (cfg.index == spi_eas_pkg::CFG_PAGE_SIZE_LOG2) page_size_log2 <= cfg.data[3:0];
      if (cfg.index == spi_eas_pkg::CFG_TIMEOUT_MS)     timeout_ms     <= cfg.data;
    end
  end

  // an item is taken whenever the queue has a free slot
  assign req.ready = space;
  assign fire      = req.valid && space;

  spi_eas_core u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .kind           (req.kind),
    .address        (req.address),
    .length         (req.length),
    .data_byte      (req.data_byte),
    .page_size_log2 (page_size_log2),
    .timeout_ms     (timeout_ms),
    .push           (push),
    .bundle         (bundle)
  );

  spi_eas_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .bundle (bundle),
    .space  (space),
    .valid  (rsp.valid),
    .ready  (rsp.ready),
    .action (rsp.action),
    .value  (rsp.value),
    .last   (rsp.last)
  );

  a_rst_cfg: assert property (@(posedge clk)
    rst |=> page_size_log2 == spi_eas_pkg::PAGE_SIZE_LOG2_RST
            && timeout_ms == spi_eas_pkg::TIMEOUT_MS_RST && !rsp.valid)
    else $error("reset did not restore defaults");

  a_push_on_fire: assert property (@(posedge clk) disable iff (rst)
    push |-> fire)
    else $error("results without an accepted item");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> rsp.valid)
    else $error("request stalled with nothing to deliver");

endmodule

>>> sim/spi_eeprom_access_sequencer_unit_tb.sv
// testbench of the spi eeprom access sequencer: directed table, random sequences, predictor
`timescale 1ns / 100ps

module spi_eeprom_access_sequencer_unit_tb;
  import spi_eas_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam int PHASE_ITEMS   = 55;

  // one expected result with its end-of-item flag
  typedef struct packed {
    result_t res;
    logic    last;
  } spi_act_t;

  // one row of the directed table; typed rows carry their results, others use the predictor
  typedef struct packed {
    logic [2:0]       kind;
    logic [23:0]      address;
    logic [15:0]      length;
    logic [7:0]       data_byte;
    logic             typed;
    logic [2:0]       cnt;
    result_t [3:0]    res;
  } plan_row_t;

  logic clk;
  logic rst;

  spi_eas_req_if req_ch ();
  spi_eas_rsp_if rsp_ch ();
  spi_eas_cfg_if cfg_ch ();

  spi_eeprom_access_sequencer_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // predictor copy of the configuration registers
  logic [3:0]  page_log2   = PAGE_SIZE_LOG2_RST;
  logic [15:0] timeout_lim = TIMEOUT_MS_RST;

  // predictor copy of the sequencer state
  phase_t      seq_phase  = PH_IDLE;
  logic        wr_op      = 1'b0;
  logic [23:0] cur_addr   = '0;
  logic [15:0] bytes_left = '0;
  logic [15:0] tick_cnt   = '0;
  logic [1:0]  hdr_idx    = '0;

  result_t     step_out[$];          // results of the item just accepted
  spi_act_t    expected_actions[$];  // results still owed by the block
  plan_row_t   plan[$];

  int  mismatches    = 0;
  int  items_sent    = 0;
  int  cycle_cnt     = 0;
  int  rx_hold_cycles = 0;
  bit  tx_idle_on    = 1'b1;
  bit  rx_idle_on    = 1'b1;

  // clock, 4 ns period
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic result_t rr(input action_t act, input logic [7:0] val);
    result_t r;
    r.action = act;
    r.value  = val;
    return r;
  endfunction

  function automatic void emit(input action_t act, input logic [7:0] val);
    step_out.push_back(rr(act, val));
  endfunction

  // status poll frame: select low, read status command; tick count starts over
  function automatic void start_poll();
    tick_cnt = '0;
    emit(ACT_SEL_LOW, DUMMY);
    emit(ACT_XCHG, CMD_RDSR);
    seq_phase = PH_POLL_CMD;
  endfunction

  function automatic void start_header();
    emit(ACT_SEL_LOW, DUMMY);
    emit(ACT_XCHG, wr_op ? CMD_WRITE : CMD_READ);
    seq_phase = PH_HDR_CMD;
  endfunction

  // address bytes go out high byte first
  function automatic void send_addr();
    emit(ACT_XCHG, 8'(cur_addr >> (16 - 8 * hdr_idx)));
    seq_phase = PH_HDR_ADDR;
  endfunction

  function automatic void close_op(input logic [7:0] status);
    emit(ACT_SEL_HIGH, DUMMY);
    emit(ACT_DONE, status);
    seq_phase = PH_IDLE;
  endfunction

  // works out the results of one accepted item into step_out
  function automatic void step_sequencer(input logic [2:0] k, input logic [23:0] a,
                                         input logic [15:0] l, input logic [7:0] d);
    step_out.delete();
    case (k)
      KIND_START_RD, KIND_START_WR: begin
        // a start while an operation runs is dropped
        if (seq_phase == PH_IDLE) begin
          wr_op      = (k == KIND_START_WR);
          cur_addr   = a;
          bytes_left = l;
          hdr_idx    = '0;
          start_poll();
        end
      end
      KIND_TICK: begin
        // ticks only count during a busy wait, saturating
        if ((seq_phase == PH_POLL_CMD || seq_phase == PH_POLL_STAT) && tick_cnt != TICKS_MAX)
          tick_cnt++;
      end
      KIND_PAYLOAD: begin
        if (seq_phase == PH_WR_PAYLOAD) begin
          emit(ACT_XCHG, d);
          seq_phase = PH_WR_DATA;
        end
      end
      KIND_REPLY: begin
        case (seq_phase)
          PH_POLL_CMD: begin
            emit(ACT_XCHG, DUMMY);
            seq_phase = PH_POLL_STAT;
          end
          PH_POLL_STAT: begin
            if (d[0]) begin
              if (tick_cnt >= timeout_lim) begin
                close_op(STATUS_TIMEOUT);
              end else begin
                emit(ACT_SEL_HIGH, DUMMY);
                emit(ACT_SEL_LOW, DUMMY);
                emit(ACT_XCHG, CMD_RDSR);
                seq_phase = PH_POLL_CMD;
              end
            end else begin
              emit(ACT_SEL_HIGH, DUMMY);
              if (wr_op) begin
                emit(ACT_SEL_LOW, DUMMY);
                emit(ACT_XCHG, CMD_WREN);
                seq_phase = PH_WREN;
              end else begin
                start_header();
              end
            end
          end
          PH_WREN: begin
            emit(ACT_SEL_HIGH, DUMMY);
            start_header();
          end
          PH_HDR_CMD: begin
            hdr_idx = '0;
            send_addr();
          end
          PH_HDR_ADDR: begin
            if (hdr_idx >= 2) begin
              hdr_idx = '0;
              if (bytes_left == 0) begin
                close_op(STATUS_OK);
              end else if (wr_op) begin
                seq_phase = PH_WR_PAYLOAD;
              end else begin
                emit(ACT_XCHG, DUMMY);
                seq_phase = PH_RD_DATA;
              end
            end else begin
              hdr_idx++;
              send_addr();
            end
          end
          PH_RD_DATA: begin
            emit(ACT_READ, d);
            bytes_left--;
            cur_addr++;
            if (bytes_left == 0)
              close_op(STATUS_OK);
            else
              emit(ACT_XCHG, DUMMY);
          end
          PH_WR_DATA: begin
            bytes_left--;
            cur_addr++;
            // the final byte closes the write even on a page boundary
            if (bytes_left == 0) begin
              close_op(STATUS_OK);
            end else if ((32'(cur_addr) & ((32'd1 << page_log2) - 32'd1)) == 0) begin
              emit(ACT_SEL_HIGH, DUMMY);
              start_poll();
            end else begin
              seq_phase = PH_WR_PAYLOAD;
            end
          end
          default: ;
        endcase
      end
      default: ;  // kinds 5 to 7 do nothing
    endcase
  endfunction

  // queue the results of the last step, marking the final one
  function automatic void commit_step();
    spi_act_t e;
    foreach (step_out[i]) begin
      e.res  = step_out[i];
      e.last = (i == step_out.size() - 1);
      expected_actions.push_back(e);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------------

  // offers one item and returns at the edge where it is taken; valid stays up
  // so a back-to-back item can follow in the same step
  task automatic send_item(input logic [2:0] k, input logic [23:0] a,
                           input logic [15:0] l, input logic [7:0] d);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.kind      <= k;
    req_ch.address   <= a;
    req_ch.length    <= l;
    req_ch.data_byte <= d;
    req_ch.valid     <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic apply_item(input logic [2:0] k, input logic [23:0] a,
                            input logic [15:0] l, input logic [7:0] d);
    send_item(k, a, l, d);
    step_sequencer(k, a, l, d);
    commit_step();
    items_sent++;
  endtask

  // stop offering, let every owed result arrive, then let the block settle
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers back to back, valid held across the two writes
  task automatic set_config(input logic [3:0] pg, input logic [15:0] lim);
    cfg_ch.index <= CFG_PAGE_SIZE_LOG2;
    cfg_ch.data  <= 16'(pg);
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    page_log2    = pg;
    cfg_ch.index <= CFG_TIMEOUT_MS;
    cfg_ch.data  <= lim;
    do @(posedge clk); while (!cfg_ch.ready);
    timeout_lim  = lim;
    cfg_ch.valid <= 1'b0;
  endtask

  // addresses biased toward page ends and the top of the address space
  function automatic logic [23:0] pick_address();
    case ($urandom_range(0, 3))
      0:       return 24'($urandom);
      1:       return {16'($urandom), 8'hf8 | 8'($urandom_range(0, 7))};
      2:       return 24'hfffff0 | 24'($urandom_range(0, 15));
      default: return {18'($urandom), 6'd0};
    endcase
  endfunction

  // mostly short transfers, a few longer ones
  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 70) return 16'($urandom_range(1, 6));
    if (r < 95) return 16'($urandom_range(7, 20));
    return 16'($urandom_range(21, 48));
  endfunction

  // one complete read or write, answering whatever the sequencer waits for,
  // with ticks in busy waits and some stray items mixed in
  task automatic run_operation();
    logic [2:0] k;
    logic       busy;
    k = $urandom_range(0, 1) ? KIND_START_WR : KIND_START_RD;
    apply_item(k, pick_address(), pick_length(), 8'($urandom));
    while (seq_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < 12) begin
        // noise: any kind with any content, bad kinds among them
        apply_item(3'($urandom_range(0, 7)), 24'($urandom), 16'($urandom), 8'($urandom));
      end else begin
        case (seq_phase)
          PH_POLL_CMD, PH_POLL_STAT: begin
            repeat ($urandom_range(0, 2))
              apply_item(KIND_TICK, 24'($urandom), 16'($urandom), 8'($urandom));
            busy = ($urandom_range(0, 99) < 30);
            apply_item(KIND_REPLY, 24'($urandom), 16'($urandom), {7'($urandom), busy});
          end
          PH_WR_PAYLOAD:
            apply_item(KIND_PAYLOAD, 24'($urandom), 16'($urandom), 8'($urandom));
          default:
            apply_item(KIND_REPLY, 24'($urandom), 16'($urandom), 8'($urandom));
        endcase
      end
    end
  endtask

  task automatic run_random(input int goal);
    while (items_sent < goal) begin
      // idling switched per operation so some stretches run flat out
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      run_operation();
    end
  endtask

  function automatic void add_row(input logic [2:0] k, input logic [23:0] a,
                                  input logic [15:0] l, input logic [7:0] d,
                                  input int cnt = -1,
                                  input result_t r0 = '0, input result_t r1 = '0,
                                  input result_t r2 = '0, input result_t r3 = '0);
    plan_row_t row;
    row.kind      = k;
    row.address   = a;
    row.length    = l;
    row.data_byte = d;
    row.typed     = (cnt >= 0);
    row.cnt       = (cnt >= 0) ? 3'(cnt) : 3'd0;
    row.res[0]    = r0;
    row.res[1]    = r1;
    row.res[2]    = r2;
    row.res[3]    = r3;
    plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int page_plan[7];
    int limit_plan[7];

    page_plan  = '{8, 0, 15, 2, 1, 3, 9};
    limit_plan = '{100, 0, 65535, 3, 1, 6, 2};

    req_ch.valid     <= 1'b0;
    req_ch.kind      <= KIND_TICK;
    req_ch.address   <= '0;
    req_ch.length    <= '0;
    req_ch.data_byte <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_PAGE_SIZE_LOG2;
    cfg_ch.data      <= '0;
    rst              <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset configuration: page 256, timeout 100
    // bad kind and a stray reply while idle do nothing
    add_row(3'd7, 24'hffffff, 16'hffff, 8'hff, 0);
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'h00, 0);
    // read two bytes at the top of the address space
    add_row(KIND_START_RD, 24'hffffff, 16'd2, 8'h00, 2,
            rr(ACT_SEL_LOW, DUMMY), rr(ACT_XCHG, CMD_RDSR));
    // start while active is dropped
    add_row(KIND_START_WR, 24'h000000, 16'hffff, 8'h00, 0);
    add_row(KIND_TICK, 24'h000000, 16'h0000, 8'h00, 0);
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'hff, 1, rr(ACT_XCHG, DUMMY));
    // device busy, well inside the timeout: poll again
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'h01, 3,
            rr(ACT_SEL_HIGH, DUMMY), rr(ACT_SEL_LOW, DUMMY), rr(ACT_XCHG, CMD_RDSR));
    // payload byte in a poll is unexpected
    add_row(KIND_PAYLOAD, 24'h000000, 16'h0000, 8'h5a, 0);
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'h00, 1, rr(ACT_XCHG, DUMMY));
    // ready with every other status bit set
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'hfe, 3,
            rr(ACT_SEL_HIGH, DUMMY), rr(ACT_SEL_LOW, DUMMY), rr(ACT_XCHG, CMD_READ));
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'h00, 1, rr(ACT_XCHG, 8'hff));
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'h00, 1, rr(ACT_XCHG, 8'hff));
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'h00, 1, rr(ACT_XCHG, 8'hff));
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'h00, 1, rr(ACT_XCHG, DUMMY));
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'ha5, 2,
            rr(ACT_READ, 8'ha5), rr(ACT_XCHG, DUMMY));
    // last read byte, address wraps past the top
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'h5a, 3,
            rr(ACT_READ, 8'h5a), rr(ACT_SEL_HIGH, DUMMY), rr(ACT_DONE, STATUS_OK));
    // zero length write: header still goes out, then done
    add_row(KIND_START_WR, 24'h0000ff, 16'd0, 8'hff);
    add_row(KIND_REPLY, 24'hffffff, 16'hffff, 8'hff);
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'h00, 3,
            rr(ACT_SEL_HIGH, DUMMY), rr(ACT_SEL_LOW, DUMMY), rr(ACT_XCHG, CMD_WREN));
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'h00, 3,
            rr(ACT_SEL_HIGH, DUMMY), rr(ACT_SEL_LOW, DUMMY), rr(ACT_XCHG, CMD_WRITE));
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'h00);
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'h00);
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'h00);
    add_row(KIND_REPLY, 24'h000000, 16'h0000, 8'h00, 2,
            rr(ACT_SEL_HIGH, DUMMY), rr(ACT_DONE, STATUS_OK));

    foreach (plan[i]) begin
      send_item(plan[i].kind, plan[i].address, plan[i].length, plan[i].data_byte);
      step_sequencer(plan[i].kind, plan[i].address, plan[i].length, plan[i].data_byte);
      if (plan[i].typed) begin
        step_out.delete();
        for (int j = 0; j < plan[i].cnt; j++)
          step_out.push_back(plan[i].res[j]);
      end
      commit_step();
      items_sent++;
    end

    // random phases, each under its own register setting; the sender pauses
    // between phases until every result is in
    for (int p = 0; p < 7; p++) begin
      drain();
      if (p != 0)
        set_config(4'(page_plan[p]), 16'(limit_plan[p]));
      if (p == 5) begin
        // receiver holds off while the sender keeps pushing, so the block backs up
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        run_operation();
        run_operation();
      end
      run_random(plan.size() + (p + 1) * PHASE_ITEMS);
    end

    drain();
    if (mismatches == 0 && expected_actions.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver: random wait per item, or a long hold when asked
  initial begin
    int hold;
    rsp_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        hold           = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        hold = rx_idle_on ? $urandom_range(0, 10) : 0;
      end
      if (hold > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // each accepted result against the oldest one owed
  always @(posedge clk) begin
    spi_act_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_actions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: action %0d value %h last %0d",
                   rsp_ch.action, rsp_ch.value, rsp_ch.last);
      end else begin
        want = expected_actions.pop_front();
        if (rsp_ch.action !== want.res.action || rsp_ch.value !== want.res.value ||
            rsp_ch.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%h/%0d, got %0d/%h/%0d (action/value/last)",
                     want.res.action, want.res.value, want.last,
                     rsp_ch.action, rsp_ch.value, rsp_ch.last);
        end
      end
    end
  end

  // run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule
